FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted list table engine
// Implication checks, same cycle and next cycle, with reset masking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: src/slte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slte_pkg
// Shared sizes, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package slte_pkg;

   localparam int DEPTH    = 16;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int VALUE_W  = 32;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;

   typedef logic signed [VALUE_W-1:0] value_type;

   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DUMP   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_TOP,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_VAL_UP,
      WR_DOUT_UP,
      WR_VAL_HEAD,
      WR_COMPACT
   } wr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_CLEAR,
      CNT_COMPACT
   } cnt_op_type;

   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_SINGLE,
      OUT_DUMP
   } out_op_type;

   typedef struct packed {
      logic                load;
      ptr_op_type          ptr_op;
      logic                rd_en;
      wr_op_type           wr_op;
      cnt_op_type          cnt_op;
      logic                hit_clr;
      logic                hit_upd;
      out_op_type          out_op;
      logic [STATUS_W-1:0] out_status;
      logic                out_found;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic at_last;
      logic ptr_zero;
      logic dout_le;
      logic dout_eq;
      logic hit;
      logic slot_free;
   } stat_type;

endpackage

FILE: src/slte_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slte_req_if
// Request channel: operation code and operand value.
// ----------------------------------------------------------------------------
interface slte_req_if import slte_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   value_type         item_value;

   modport source (output valid, output mode, output item_value, input ready);
   modport sink   (input valid, input mode, input item_value, output ready);
endinterface

FILE: src/slte_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slte_rsp_if
// Response channel: status, search flag, dump entry, count and last mark.
// ----------------------------------------------------------------------------
interface slte_rsp_if import slte_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                found;
   value_type           entry_value;
   logic [CNT_W-1:0]    entry_count;
   logic                last;

   modport source (output valid, output status, output found, output entry_value,
                   output entry_count, output last, input ready);
   modport sink   (input valid, input status, input found, input entry_value,
                   input entry_count, input last, output ready);
endinterface

FILE: src/slte_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slte_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/slte_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slte_datapath
// List store, pointers, entry count, match flag and response register.
// ----------------------------------------------------------------------------
module slte_datapath import slte_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  value_type           item_value,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_found,
   output value_type           rsp_entry_value,
   output logic [CNT_W-1:0]    rsp_entry_count,
   output logic                rsp_last
);

   value_type           value_ff, value_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                hit_ff, hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_found_ff, rsp_found_in;
   value_type           rsp_entry_ff, rsp_entry_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]    count_dec;
   logic [CNT_W-1:0]    ptr_ext;
   logic [IDX_W-1:0]    ptr_up;
   value_type           ram_dout;
   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   value_type           ram_wr_data;
   logic                at_last;
   logic                dout_eq;
   logic                slot_free;

   slte_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (ptr_in),
      .rd_data (ram_dout)
   );

   assign count_dec = count_ff - CNT_W'(1);
   assign ptr_ext   = {{(CNT_W-IDX_W){1'b0}}, ptr_ff};
   assign ptr_up    = ptr_ff + IDX_W'(1);
   assign at_last   = (ptr_ext + CNT_W'(1)) == count_ff;
   assign dout_eq   = ram_dout == value_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      stat.count_zero = count_ff == '0;
      stat.count_full = count_ff == CNT_W'(DEPTH);
      stat.at_last    = at_last;
      stat.ptr_zero   = ptr_ff == '0;
      stat.dout_le    = ram_dout <= value_ff;
      stat.dout_eq    = dout_eq;
      stat.hit        = hit_ff;
      stat.slot_free  = slot_free;
   end

   // pointer and store write port
   always_comb begin
      value_in  = cmd.load ? item_value : value_ff;
      wr_ptr_in = wr_ptr_ff;
      case (cmd.ptr_op)
         PTR_HOLD: ptr_in = ptr_ff;
         PTR_ZERO: begin
            ptr_in    = '0;
            wr_ptr_in = '0;
         end
         PTR_TOP:  ptr_in = count_dec[IDX_W-1:0];
         PTR_INC:  ptr_in = ptr_up;
         PTR_DEC:  ptr_in = ptr_ff - IDX_W'(1);
         default:  ptr_in = ptr_ff;
      endcase

      ram_wr_en   = 1'b0;
      ram_wr_addr = ptr_up;
      ram_wr_data = value_ff;
      case (cmd.wr_op)
         WR_NONE: ;
         WR_VAL_UP: ram_wr_en = 1'b1;
         WR_DOUT_UP: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_dout;
         end
         WR_VAL_HEAD: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
         end
         WR_COMPACT: begin
            // keep entries that do not match, close the gap
            ram_wr_en   = !dout_eq;
            ram_wr_addr = wr_ptr_ff[IDX_W-1:0];
            ram_wr_data = ram_dout;
            if (!dout_eq) begin
               wr_ptr_in = wr_ptr_ff + CNT_W'(1);
            end
         end
         default: ;
      endcase

      case (cmd.cnt_op)
         CNT_HOLD:    count_in = count_ff;
         CNT_INC:     count_in = count_ff + CNT_W'(1);
         CNT_CLEAR:   count_in = '0;
         CNT_COMPACT: count_in = wr_ptr_ff + {{(CNT_W-1){1'b0}}, !dout_eq};
         default:     count_in = count_ff;
      endcase

      if (cmd.hit_clr) begin
         hit_in = 1'b0;
      end else if (cmd.hit_upd) begin
         hit_in = hit_ff || dout_eq;
      end else begin
         hit_in = hit_ff;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      case (cmd.out_op)
         OUT_NONE: ;
         OUT_SINGLE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = cmd.out_status;
            rsp_found_in  = cmd.out_found && hit_ff;
            rsp_entry_in  = '0;
            rsp_count_in  = count_ff;
            rsp_last_in   = 1'b1;
         end
         OUT_DUMP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_DONE;
            rsp_found_in  = 1'b0;
            rsp_entry_in  = ram_dout;
            rsp_count_in  = count_ff;
            rsp_last_in   = at_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff      <= value_in;
      ptr_ff        <= ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_entry_value = rsp_entry_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

FILE: src/slte_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slte_controller
// Request sequencer: decodes the operation and steps the store walks.
// ----------------------------------------------------------------------------
module slte_controller import slte_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [MODE_W-1:0] req_mode,
   input  stat_type          stat,
   output cmd_type           cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS_WALK,
      S_INS_HEAD,
      S_RM_WALK,
      S_SR_WALK,
      S_DUMP,
      S_RESULT,
      S_RM_RESULT
   } state_type;

   state_type           state_ff, state_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                res_found_ff, res_found_in;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      req_ready     = 1'b0;

      cmd            = '0;
      cmd.ptr_op     = PTR_HOLD;
      cmd.wr_op      = WR_NONE;
      cmd.cnt_op     = CNT_HOLD;
      cmd.out_op     = OUT_NONE;
      cmd.out_status = ST_DONE;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               mode_in  = req_mode;
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            res_status_in = ST_DONE;
            res_found_in  = 1'b0;
            state_in      = S_RESULT;
            case (mode_ff)
               MODE_INSERT: begin
                  if (stat.count_full) begin
                     res_status_in = ST_FULL;
                  end else if (stat.count_zero) begin
                     cmd.wr_op  = WR_VAL_HEAD;
                     cmd.cnt_op = CNT_INC;
                  end else begin
                     // walk down from the top entry
                     cmd.ptr_op = PTR_TOP;
                     cmd.rd_en  = 1'b1;
                     state_in   = S_INS_WALK;
                  end
               end
               MODE_REMOVE: begin
                  cmd.hit_clr = 1'b1;
                  if (stat.count_zero) begin
                     state_in = S_RM_RESULT;
                  end else begin
                     cmd.ptr_op = PTR_ZERO;
                     cmd.rd_en  = 1'b1;
                     state_in   = S_RM_WALK;
                  end
               end
               MODE_SEARCH: begin
                  cmd.hit_clr  = 1'b1;
                  res_found_in = 1'b1;
                  if (!stat.count_zero) begin
                     cmd.ptr_op = PTR_ZERO;
                     cmd.rd_en  = 1'b1;
                     state_in   = S_SR_WALK;
                  end
               end
               MODE_CLEAR: cmd.cnt_op = CNT_CLEAR;
               MODE_DUMP: begin
                  if (stat.count_zero) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     cmd.ptr_op = PTR_ZERO;
                     cmd.rd_en  = 1'b1;
                     state_in   = S_DUMP;
                  end
               end
               default: ;
            endcase
         end

         S_INS_WALK: begin
            if (stat.dout_le) begin
               // drop the new value in above the first entry not larger
               cmd.wr_op  = WR_VAL_UP;
               cmd.cnt_op = CNT_INC;
               state_in   = S_RESULT;
            end else begin
               cmd.wr_op = WR_DOUT_UP;
               if (stat.ptr_zero) begin
                  state_in = S_INS_HEAD;
               end else begin
                  cmd.ptr_op = PTR_DEC;
                  cmd.rd_en  = 1'b1;
               end
            end
         end

         S_INS_HEAD: begin
            cmd.wr_op  = WR_VAL_HEAD;
            cmd.cnt_op = CNT_INC;
            state_in   = S_RESULT;
         end

         S_RM_WALK: begin
            cmd.hit_upd = 1'b1;
            cmd.wr_op   = WR_COMPACT;
            if (stat.at_last) begin
               cmd.cnt_op = CNT_COMPACT;
               state_in   = S_RM_RESULT;
            end else begin
               cmd.ptr_op = PTR_INC;
               cmd.rd_en  = 1'b1;
            end
         end

         S_SR_WALK: begin
            cmd.hit_upd = 1'b1;
            if (stat.at_last) begin
               state_in = S_RESULT;
            end else begin
               cmd.ptr_op = PTR_INC;
               cmd.rd_en  = 1'b1;
            end
         end

         S_DUMP: begin
            if (stat.slot_free) begin
               cmd.out_op = OUT_DUMP;
               if (stat.at_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.ptr_op = PTR_INC;
                  cmd.rd_en  = 1'b1;
               end
            end
         end

         S_RESULT: begin
            if (stat.slot_free) begin
               cmd.out_op     = OUT_SINGLE;
               cmd.out_status = res_status_ff;
               cmd.out_found  = res_found_ff;
               state_in       = S_IDLE;
            end
         end

         S_RM_RESULT: begin
            if (stat.slot_free) begin
               cmd.out_op     = OUT_SINGLE;
               cmd.out_status = stat.hit ? ST_DONE : ST_NOT_FOUND;
               state_in       = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= MODE_INSERT;
         res_status_ff <= ST_DONE;
         res_found_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         res_status_ff <= res_status_in;
         res_found_ff  <= res_found_in;
      end
   end

endmodule

FILE: src/sorted_list_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_table_engine
// Ascending list of signed 32-bit values with insert, remove, search, clear
// and dump requests.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake           | item
//  ---------+-----+---------------------+-------------------------------------
//  req_ch   | in  | valid / ready       | mode, item_value
//  rsp_ch   | out | valid / ready       | status, found, entry_value,
//           |     |                     | entry_count, last
//
//  One request at a time. Insert, remove and search walk the list through the
//  single store read port, one entry per cycle. A dump gives one item per
//  cycle while rsp_ch.ready stays high. Reset is synchronous; the entry count
//  resets to zero and the store is not cleared, so no clearing pass runs. A
//  stalled response holds in the output register; the next request is taken
//  while it waits.
//
`include "assert_macros.svh"

module sorted_list_table_engine import slte_pkg::*; (
   input logic         clock,
   input logic         reset,
   slte_req_if.sink    req_ch,
   slte_rsp_if.source  rsp_ch
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: decodes the request and drives the walks
   slte_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_mode  (req_ch.mode),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store, pointers, count and response register
   slte_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .item_value      (req_ch.item_value),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_status      (rsp_ch.status),
      .rsp_found       (rsp_ch.found),
      .rsp_entry_value (rsp_ch.entry_value),
      .rsp_entry_count (rsp_ch.entry_count),
      .rsp_last        (rsp_ch.last)
   );

   // the block is busy in the cycle after it takes a request
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   // a response is only loaded when the output register can take it
   `ASSERT_IMPL(a_load_into_free_slot, clock, reset, cmd.out_op != OUT_NONE, stat.slot_free)
   // empty-list dump: one final item with zero count
   `ASSERT_IMPL(a_empty_dump, clock, reset, rsp_ch.valid && rsp_ch.status == ST_EMPTY, rsp_ch.last && rsp_ch.entry_count == '0)
   // a search hit is a single completed item
   `ASSERT_IMPL(a_found_done, clock, reset, rsp_ch.valid && rsp_ch.found, rsp_ch.status == ST_DONE && rsp_ch.last)

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted list table engine. Requests go in
// through a bursty sender and results come out through a receiver that
// stalls on a pattern of its own. A shadow copy of the list predicts every
// result, which is checked field by field.
// ----------------------------------------------------------------------------
module tb import slte_pkg::*; ();

   // modes the block must ignore, answering with a plain done item
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   localparam int RANDOM_ITEMS = 104;
   localparam int LONG_HOLD    = 250;

   typedef struct {
      logic [MODE_W-1:0] mode;
      value_type         operand;
   } list_op_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic                found;
      value_type           entry;
      logic [CNT_W-1:0]    count;
      logic                last;
   } list_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // tb-side drivers, so every input is known from time zero
   logic              send_valid = 1'b0;
   logic [MODE_W-1:0] send_mode  = MODE_SEARCH;
   value_type         send_value = '0;
   logic              take_ready = 1'b0;

   slte_req_if req_ch ();
   slte_rsp_if rsp_ch ();

   assign req_ch.valid      = send_valid;
   assign req_ch.mode       = send_mode;
   assign req_ch.item_value = send_value;
   assign rsp_ch.ready      = take_ready;

   sorted_list_table_engine uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // requests still to be offered, and results the shadow list says must come
   list_op_type  op_backlog[$];
   list_rsp_type rsp_awaited[$];

   // shadow copy of the block's list
   value_type shadow_list [DEPTH];
   int        shadow_count = 0;

   int err_count = 0;

   // --------------------------------------------------------------------------
   // Clock and reset
   // --------------------------------------------------------------------------
   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Hard stop in case the block hangs
   initial begin
      #1_000_000;
      $display("sorted_list_table_engine: mismatch");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Shadow list: apply one accepted request and queue the results it causes
   // --------------------------------------------------------------------------
   function automatic void apply_to_shadow(input list_op_type op);
      list_rsp_type r;
      int           pos;
      int           wr;
      int           k;
      bit           hit;
      r.status = ST_DONE;
      r.found  = 1'b0;
      r.entry  = '0;
      r.count  = '0;
      r.last   = 1'b1;
      case (op.mode)
         MODE_INSERT: begin
            if (shadow_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               // land after any equal entries, push larger ones up
               pos = 0;
               while (pos < shadow_count && shadow_list[pos] <= op.operand) pos++;
               for (k = shadow_count; k > pos; k--) shadow_list[k] = shadow_list[k-1];
               shadow_list[pos] = op.operand;
               shadow_count++;
            end
         end
         MODE_REMOVE: begin
            // drop every copy and close the gap
            wr  = 0;
            hit = 1'b0;
            for (k = 0; k < shadow_count; k++) begin
               if (shadow_list[k] == op.operand) begin
                  hit = 1'b1;
               end else begin
                  shadow_list[wr] = shadow_list[k];
                  wr++;
               end
            end
            shadow_count = wr;
            if (!hit) r.status = ST_NOT_FOUND;
         end
         MODE_SEARCH: begin
            for (k = 0; k < shadow_count; k++)
               if (shadow_list[k] == op.operand) r.found = 1'b1;
         end
         MODE_CLEAR: begin
            shadow_count = 0;
         end
         MODE_DUMP: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               // one item per entry, last mark on the top one
               for (k = 0; k < shadow_count; k++) begin
                  r.entry = shadow_list[k];
                  r.count = CNT_W'(shadow_count);
                  r.last  = (k == shadow_count - 1);
                  rsp_awaited.push_back(r);
               end
               return;
            end
         end
         default: ;
      endcase
      r.count = CNT_W'(shadow_count);
      rsp_awaited.push_back(r);
   endfunction

   // --------------------------------------------------------------------------
   // Stimulus helpers
   // --------------------------------------------------------------------------
   function automatic void queue_op(input logic [MODE_W-1:0] m, input value_type v);
      list_op_type op;
      op.mode    = m;
      op.operand = v;
      op_backlog.push_back(op);
   endfunction

   // mostly a narrow band of values so duplicates and remove hits are common
   function automatic value_type pick_operand();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return value_type'($urandom_range(0, 7)) - 4;
      if (sel < 7) begin
         case ($urandom_range(0, 3))
            0:       return {1'b1, {(VALUE_W-1){1'b0}}};
            1:       return {1'b0, {(VALUE_W-1){1'b1}}};
            2:       return '0;
            default: return '1;
         endcase
      end
      return value_type'($urandom);
   endfunction

   // --------------------------------------------------------------------------
   // Stimulus and end of run
   // --------------------------------------------------------------------------
   initial begin : stimulus
      int                n;
      int                seg_left;
      int                roll;
      bit                filling;
      logic [MODE_W-1:0] m;

      // empty list: dump gives the empty status, remove misses, search misses
      queue_op(MODE_DUMP, '0);
      queue_op(MODE_REMOVE, 32'sd12);
      queue_op(MODE_SEARCH, 32'sd12);

      // fill to the brim, extremes and duplicates included
      queue_op(MODE_INSERT, {1'b0, {(VALUE_W-1){1'b1}}});
      queue_op(MODE_INSERT, {1'b1, {(VALUE_W-1){1'b0}}});
      queue_op(MODE_INSERT, 32'sd0);
      queue_op(MODE_INSERT, 32'sd0);
      queue_op(MODE_INSERT, -32'sd1);
      queue_op(MODE_INSERT, 32'sd1);
      queue_op(MODE_INSERT, 32'sd7);
      queue_op(MODE_INSERT, 32'sd7);
      queue_op(MODE_INSERT, 32'sd7);
      queue_op(MODE_INSERT, -32'sd100);
      queue_op(MODE_INSERT, 32'sd100);
      queue_op(MODE_INSERT, 32'sh4000_0000);
      queue_op(MODE_INSERT, 32'shBFFF_FFFF);
      queue_op(MODE_INSERT, 32'sh5555_5555);
      queue_op(MODE_INSERT, 32'shAAAA_AAAA);
      queue_op(MODE_INSERT, {1'b0, {(VALUE_W-1){1'b1}}});

      // full list refuses, then dump all sixteen
      queue_op(MODE_INSERT, 32'sd5);
      queue_op(MODE_DUMP, '0);

      // remove every copy of a repeated value, search a present one
      queue_op(MODE_REMOVE, 32'sd7);
      queue_op(MODE_SEARCH, 32'sd0);

      // spare modes leave the list alone
      queue_op(MODE_SPARE_LO, 32'sd100);
      queue_op(MODE_SPARE_HI, -32'sd1);

      queue_op(MODE_CLEAR, '1);

      // random part: stretches of random kind, either insert-heavy ones that fill
      // the list or mixed ones that drain, clear and dump it
      seg_left = 0;
      filling  = 1'b0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (seg_left == 0) begin
            filling  = 1'($urandom_range(0, 1));
            seg_left = $urandom_range(10, 30);
         end
         seg_left--;
         roll = $urandom_range(0, 99);
         if (filling) begin
            if (roll < 70)      m = MODE_INSERT;
            else if (roll < 80) m = MODE_SEARCH;
            else if (roll < 90) m = MODE_REMOVE;
            else                m = MODE_DUMP;
         end else begin
            if (roll < 35)      m = MODE_INSERT;
            else if (roll < 55) m = MODE_REMOVE;
            else if (roll < 72) m = MODE_SEARCH;
            else if (roll < 84) m = MODE_DUMP;
            else if (roll < 92) m = MODE_CLEAR;
            else                m = MODE_W'(MODE_SPARE_LO + $urandom_range(0, 2));
         end
         queue_op(m, pick_operand());
      end

      // drain: everything offered, everything answered, then let the block settle
      wait (!reset);
      while (op_backlog.size() != 0 || send_valid) @(posedge clock);
      while (rsp_awaited.size() != 0) @(posedge clock);
      repeat (2 * (DEPTH + 3)) @(posedge clock);

      if (err_count == 0) begin
         $display("sorted_list_table_engine: match");
      end else begin
         $display("sorted_list_table_engine: mismatch");
      end
      $finish;
   end

   // --------------------------------------------------------------------------
   // Sender: bursts of random length separated by random gaps. An offered
   // item holds until it is taken; the shadow list advances on acceptance.
   // --------------------------------------------------------------------------
   list_op_type offer;
   int          burst_left = 0;
   int          gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         send_valid <= 1'b0;
         burst_left  = $urandom_range(1, 12);
         gap_left    = 0;
      end else begin
         if (send_valid && req_ch.ready) apply_to_shadow(offer);

         if (send_valid && !req_ch.ready) begin
            // hold the current item
         end else if (gap_left > 0) begin
            gap_left--;
            send_valid <= 1'b0;
         end else if (op_backlog.size() != 0) begin
            offer = op_backlog.pop_front();
            send_valid <= 1'b1;
            send_mode  <= offer.mode;
            send_value <= offer.operand;
            if (burst_left <= 1) begin
               // burst over: pick the next one and the gap before it
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            send_valid <= 1'b0;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Receiver: stall style is redrawn after each random-length phase (always
   // ready, coin toss, mostly stalled). Once, after some traffic, hold off for a
   // long stretch so the output register fills and the block stops taking input.
   // --------------------------------------------------------------------------
   int stall_style = 0;
   int phase_left  = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;
   int rsp_taken   = 0;

   always @(posedge clock) begin
      if (reset) begin
         take_ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && take_ready) rsp_taken++;

         if (hold_left > 0) begin
            hold_left--;
            take_ready <= 1'b0;
         end else if (!hold_done && rsp_taken >= 30) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            take_ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               stall_style = $urandom_range(0, 2);
               phase_left  = $urandom_range(16, 64);
            end else begin
               phase_left--;
            end
            case (stall_style)
               0:       take_ready <= 1'b1;
               1:       take_ready <= 1'($urandom_range(0, 1));
               default: take_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // --------------------------------------------------------------------------
   // Checker: compare each accepted result against the oldest expectation
   // --------------------------------------------------------------------------
   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      list_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (rsp_awaited.size() == 0) begin
            $display("%0t: unexpected item, expected none, got status %0d value %0d",
                     $time, rsp_ch.status, rsp_ch.entry_value);
            err_count++;
         end else begin
            want = rsp_awaited.pop_front();
            check_field("status", want.status, rsp_ch.status);
            check_field("found", want.found, rsp_ch.found);
            check_field("entry_value", want.entry, rsp_ch.entry_value);
            check_field("entry_count", want.count, rsp_ch.entry_count);
            check_field("last", want.last, rsp_ch.last);
         end
      end
   end

endmodule
